// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the eight-bit ALU.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/eba_pkg.sv
// Shared types and opcodes for the eight-bit ALU with flags.
// No dependencies.
package eba_pkg;

    localparam int unsigned CmdW  = 5;
    localparam int unsigned DataW = 16;

    localparam logic [CmdW-1:0] CMD_CCF   = 5'd0;
    localparam logic [CmdW-1:0] CMD_SCF   = 5'd1;
    localparam logic [CmdW-1:0] CMD_CPL   = 5'd2;
    localparam logic [CmdW-1:0] CMD_AND   = 5'd3;
    localparam logic [CmdW-1:0] CMD_OR    = 5'd4;
    localparam logic [CmdW-1:0] CMD_XOR   = 5'd5;
    localparam logic [CmdW-1:0] CMD_CP    = 5'd6;
    localparam logic [CmdW-1:0] CMD_INC8  = 5'd7;
    localparam logic [CmdW-1:0] CMD_DEC8  = 5'd8;
    localparam logic [CmdW-1:0] CMD_INC16 = 5'd9;
    localparam logic [CmdW-1:0] CMD_DEC16 = 5'd10;
    localparam logic [CmdW-1:0] CMD_ADD8  = 5'd11;
    localparam logic [CmdW-1:0] CMD_ADC   = 5'd12;
    localparam logic [CmdW-1:0] CMD_SUB   = 5'd13;
    localparam logic [CmdW-1:0] CMD_SBC   = 5'd14;
    localparam logic [CmdW-1:0] CMD_ADD16 = 5'd15;
    localparam logic [CmdW-1:0] CMD_ADDSP = 5'd16;
    localparam logic [CmdW-1:0] CMD_RL    = 5'd17;
    localparam logic [CmdW-1:0] CMD_RLC   = 5'd18;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

// File: hdl/eba_alu.sv
// Combinational ALU core: result and new Z/N/H/C for one operation.
// Depends on eba_pkg.
module eba_alu
    import eba_pkg::*;
(
    input  logic [CmdW-1:0]  i_cmd,
    input  logic [DataW-1:0] i_a,
    input  logic [DataW-1:0] i_b,
    input  t_flags           i_flags,
    output logic [DataW-1:0] o_result,
    output t_flags           o_flags
);

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cin;
    logic [8:0]  add9;
    logic [4:0]  addh;
    logic [8:0]  sub9;
    logic [4:0]  subh;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [15:0] sp_sum;
    logic [7:0]  r8;

    assign a8  = i_a[7:0];
    assign b8  = i_b[7:0];
    // carry in only for ADC/SBC
    assign cin = ((i_cmd == CMD_ADC) || (i_cmd == CMD_SBC)) ? i_flags.c : 1'b0;

    assign add9  = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
    assign addh  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
    assign sub9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
    assign subh  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
    assign add17 = {1'b0, i_a} + {1'b0, i_b};
    assign add13 = {1'b0, i_a[11:0]} + {1'b0, i_b[11:0]};
    assign sp_sum = i_a + {{8{b8[7]}}, b8};

    always_comb begin
        o_result = i_a;
        o_flags  = i_flags;
        r8       = 8'h00;
        case (i_cmd)
            CMD_CCF: begin
                o_flags = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: ~i_flags.c};
            end
            CMD_SCF: begin
                o_flags = '{z: i_flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            CMD_CPL: begin
                r8       = ~a8;
                o_result = {8'h00, r8};
                o_flags  = '{z: i_flags.z, n: 1'b1, h: 1'b1, c: i_flags.c};
            end
            CMD_AND: begin
                r8       = a8 & b8;
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            CMD_OR: begin
                r8       = a8 | b8;
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_XOR: begin
                r8       = a8 ^ b8;
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_CP: begin
                o_flags = '{z: (sub9[7:0] == 8'h00), n: 1'b1, h: subh[4], c: sub9[8]};
            end
            CMD_INC8: begin
                r8       = a8 + 8'd1;
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b0, h: (a8[3:0] == 4'hF),
                             c: i_flags.c};
            end
            CMD_DEC8: begin
                r8       = a8 - 8'd1;
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b1, h: (a8[3:0] == 4'h0),
                             c: i_flags.c};
            end
            CMD_INC16: begin
                o_result = i_a + 16'd1;
            end
            CMD_DEC16: begin
                o_result = i_a - 16'd1;
            end
            CMD_ADD8, CMD_ADC: begin
                r8       = add9[7:0];
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b0, h: addh[4], c: add9[8]};
            end
            CMD_SUB, CMD_SBC: begin
                r8       = sub9[7:0];
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b1, h: subh[4], c: sub9[8]};
            end
            CMD_ADD16: begin
                o_result = add17[15:0];
                o_flags  = '{z: i_flags.z, n: 1'b0, h: add13[12], c: add17[16]};
            end
            CMD_ADDSP: begin
                // flags from the unsigned byte add, result sign-extends
                o_result = sp_sum;
                o_flags  = '{z: 1'b0, n: 1'b0, h: addh[4], c: add9[8]};
            end
            CMD_RL: begin
                r8       = {a8[6:0], i_flags.c};
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[7]};
            end
            CMD_RLC: begin
                r8       = {a8[6:0], a8[7]};
                o_result = {8'h00, r8};
                o_flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[7]};
            end
            default: begin
                o_result = i_a;
                o_flags  = i_flags;
            end
        endcase
    end

endmodule

// File: hdl/eba_flags.sv
// Flag register: holds Z/N/H/C between operations.
// Depends on eba_pkg.
module eba_flags
    import eba_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_flags i_flags,
    output t_flags o_flags
);

    t_flags r_flags;
    t_flags n_flags;

    assign n_flags = i_load ? i_flags : r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= FLAGS_RESET;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

// File: hdl/eight_bit_alu_with_flags_core.sv
// Channel | Direction | Handshake           | Payload
// in      | to block  | i_valid / o_stall   | i_cmd, i_operand_a, i_operand_b
// out     | from block| o_valid / i_stall   | o_result, o_*_flag
//
// One word per cycle while the output is not stalled; a word passes the input register,
// ALU and result register. Flags update as a word moves into the result register.
// Synchronous active-low reset clears both valid bits and the flags to zero.
// A stalled result register blocks the input register only when that is full.
// Depends on eba_pkg, eba_alu, eba_flags and assert_macros.svh.
`include "assert_macros.svh"

module eight_bit_alu_with_flags_core
    import eba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CmdW-1:0]  i_cmd,
    input  logic [DataW-1:0] i_operand_a,
    input  logic [DataW-1:0] i_operand_b,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [DataW-1:0] o_result,
    output logic             o_zero_flag,
    output logic             o_subtract_flag,
    output logic             o_half_carry_flag,
    output logic             o_carry_flag
);

    logic             r_in_valid;
    logic             n_in_valid;
    logic [CmdW-1:0]  r_cmd;
    logic [DataW-1:0] r_a;
    logic [DataW-1:0] r_b;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [DataW-1:0] r_result;
    t_flags           r_out_flags;

    logic             w_in_acc;
    logic             w_adv;
    logic [DataW-1:0] w_result;
    t_flags           w_flags_cur;
    t_flags           w_flags_new;

    // input word moves on when the result register is empty or being drained
    assign w_adv    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_adv;
    assign w_in_acc = i_valid && !o_stall;

    assign n_in_valid  = w_in_acc || (r_in_valid && !w_adv);
    assign n_out_valid = w_adv || (r_out_valid && i_stall);

    eba_alu u_alu (
        .i_cmd    (r_cmd),
        .i_a      (r_a),
        .i_b      (r_b),
        .i_flags  (w_flags_cur),
        .o_result (w_result),
        .o_flags  (w_flags_new)
    );

    eba_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv),
        .i_flags (w_flags_new),
        .o_flags (w_flags_cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_cmd;
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
        end
        if (w_adv) begin
            r_result    <= w_result;
            r_out_flags <= w_flags_new;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result          = r_result;
    assign o_zero_flag       = r_out_flags.z;
    assign o_subtract_flag   = r_out_flags.n;
    assign o_half_carry_flag = r_out_flags.h;
    assign o_carry_flag      = r_out_flags.c;

    `ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid)
    `ASSERT_NEXT(a_adv_fills, i_clk, i_rst_n, w_adv, r_out_valid)
    `ASSERT_SAME(a_flags_match, i_clk, i_rst_n, r_out_valid, r_out_flags == w_flags_cur)

endmodule
